// ----- src/rational_arith_unit_core_assert.svh -----
// Assertion macros for the rational arithmetic unit RTL (used in rau_ctrl).
`ifndef RATIONAL_ARITH_UNIT_CORE_ASSERT_SVH
`define RATIONAL_ARITH_UNIT_CORE_ASSERT_SVH
`ifndef SYNTH
`define RAU_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rau assertion failed");
`define RAU_ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("rau forbidden condition");
`else
`define RAU_ASSERT(label, clk, rst_n, prop)
`define RAU_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ----- src/rau_pkg.sv -----
// Types, codes and constants of the rational arithmetic unit.
package rau_pkg;
  localparam int unsigned WordBitsDef = 32;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_DIV  = 4'd3,
    OP_NEG  = 4'd4,
    OP_MAKE = 4'd5,
    OP_LT   = 4'd6,
    OP_EQ   = 4'd7,
    OP_LE   = 4'd8,
    OP_GT   = 4'd9,
    OP_GE   = 4'd10
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_COMB,
    ST_CHECK,
    ST_GCD,
    ST_DIVN,
    ST_SWAP,
    ST_DIVD,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [3:0]         kind;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } req_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic               cmp_true;
    logic               zero_den;
    logic               overflow;
  } res_t;

  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       comb;
    logic       gcd_step;
    logic       div_start;
    logic       div_sel;
    logic       div_step;
    logic       save_n;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic special;
    logic gcd_done;
  } sts_t;
endpackage

// ----- src/rational_arith_unit_core.sv -----
// Top level of the rational arithmetic unit.
// Usage: drive req_i (operation code and two fractions) and raise start;
// the request is taken at the clock edge where start is high and busy is low.
// busy stays high until the result has been formed; start is ignored then.
// The result appears on res_o for exactly one cycle with valid_o high.
// The receiver cannot hold results off; capture res_o when valid_o is set.
// Compare operations, zero numerators and zero denominators finish
// once the combined result has been checked. Reducing operations then
// run the binary gcd, one shift or subtract step per cycle on
// 2*WORD_BITS-bit magnitudes, followed by two one-bit-per-cycle
// divisions by the gcd, of the numerator and then of the denominator.
// A new request can be taken in the cycle valid_o is high.
// Reset (rst_ni low, asynchronous) returns the controller to idle and
// drops any request in flight; no result is issued for it.
module rational_arith_unit_core #(
  parameter int unsigned WORD_BITS = rau_pkg::WordBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  rau_pkg::req_t req_i,
  output logic          valid_o,
  output rau_pkg::res_t res_o
);
  import rau_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rau_ctrl #(.WORD_BITS(WORD_BITS)) u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .sts_i (sts),
    .cmd_o (cmd)
  );

  rau_dp #(.WORD_BITS(WORD_BITS)) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .valid_o(valid_o),
    .res_o  (res_o)
  );
endmodule

// ----- src/rau_ctrl.sv -----
// Sequencing state machine of the rational arithmetic unit.
`include "rational_arith_unit_core_assert.svh"
module rau_ctrl #(
  parameter int unsigned WORD_BITS = rau_pkg::WordBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  rau_pkg::sts_t sts_i,
  output rau_pkg::cmd_t cmd_o
);
  import rau_pkg::*;

  localparam int unsigned DW   = 2 * WORD_BITS;
  localparam int unsigned CntW = $clog2(DW);
  localparam logic [CntW-1:0] CntLast = CntW'(DW - 1);
  localparam logic [CntW-1:0] MulLast = CntW'(3);

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = cnt_q[1:0];
        cnt_d         = cnt_q + 1'b1;
        if (cnt_q == MulLast) state_d = ST_COMB;
      end
      ST_COMB: begin
        cmd_o.comb = 1'b1;
        state_d    = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts_i.special) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end else begin
          state_d = ST_GCD;
        end
      end
      ST_GCD: begin
        if (sts_i.gcd_done) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = 1'b0;
          cnt_d           = '0;
          state_d         = ST_DIVN;
        end else begin
          cmd_o.gcd_step = 1'b1;
        end
      end
      ST_DIVN: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CntLast) state_d = ST_SWAP;
      end
      ST_SWAP: begin
        cmd_o.save_n    = 1'b1;
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = 1'b1;
        cnt_d           = '0;
        state_d         = ST_DIVD;
      end
      ST_DIVD: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CntLast) state_d = ST_FIN;
      end
      ST_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy = (state_q != ST_IDLE);

  `RAU_ASSERT(a_start_mul, clk_i, rst_ni, (start && !busy) |=> (state_q == ST_MUL))
  `RAU_ASSERT(a_finish_idle, clk_i, rst_ni, cmd_o.finish |=> (state_q == ST_IDLE))
  `RAU_ASSERT_NEVER(a_mul_cnt, clk_i, rst_ni, (state_q == ST_MUL) && (cnt_q > MulLast))
endmodule

// ----- src/rau_dp.sv -----
// Datapath: operand registers, multiplier, binary gcd and restoring divider.
module rau_dp #(
  parameter int unsigned WORD_BITS = rau_pkg::WordBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rau_pkg::req_t req_i,
  input  rau_pkg::cmd_t cmd_i,
  output rau_pkg::sts_t sts_o,
  output logic          valid_o,
  output rau_pkg::res_t res_o
);
  import rau_pkg::*;

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned DW = 2 * W;
  localparam int unsigned KW = $clog2(DW);
  localparam logic [DW-1:0] Lim = DW'(1) << (W - 1);

  logic [3:0]   kind_q;
  logic [W-1:0] an_m_q, ad_m_q, bn_m_q, bd_m_q;
  logic         an_s_q, ad_s_q, bn_s_q, bd_s_q;
  logic [DW-1:0] p0_q, p1_q, p2_q, p3_q;
  logic [DW-1:0] n_m_q, d_m_q, n_m_d, d_m_d;
  logic          n_s_q, d_s_q, n_s_d, d_s_d;
  logic          cmp_q, cmp_d;
  logic [DW-1:0] u_q, v_q;
  logic [KW-1:0] k_q;
  logic [DW-1:0] dvd_q, dvs_q, rem_q, quot_q, nm_q;
  logic          valid_q;
  res_t          res_q, res_d;

  logic [W-1:0]  an_x, ad_x, bn_x, bd_x, mul_a, mul_b;
  logic [DW-1:0] prod, g, sum_b_mag;
  logic          s0, s1, s2, s3, sum_b_s, pn, qn, lt, eq, ovf, rneg;
  logic [DW:0]   trial;
  logic [DW:0]   trial_sub;
  logic [31:0]   nm32;

  assign an_x = req_i.a_num[W-1:0];
  assign ad_x = req_i.a_den[W-1:0];
  assign bn_x = req_i.b_num[W-1:0];
  assign bd_x = req_i.b_den[W-1:0];

  always_comb begin
    case (cmd_i.mul_sel)
      2'd0:    begin mul_a = an_m_q; mul_b = bd_m_q; end
      2'd1:    begin mul_a = ad_m_q; mul_b = bn_m_q; end
      2'd2:    begin mul_a = an_m_q; mul_b = bn_m_q; end
      default: begin mul_a = ad_m_q; mul_b = bd_m_q; end
    endcase
    prod = DW'(mul_a) * DW'(mul_b);
  end

  assign s0 = an_s_q ^ bd_s_q;
  assign s1 = ad_s_q ^ bn_s_q;
  assign s2 = an_s_q ^ bn_s_q;
  assign s3 = ad_s_q ^ bd_s_q;
  assign sum_b_mag = p1_q;
  assign sum_b_s   = (kind_q == OP_SUB) ? !s1 : s1;

  always_comb begin
    n_s_d = s0;
    n_m_d = p0_q;
    d_s_d = s3;
    d_m_d = p3_q;
    case (kind_q) inside
      OP_ADD, OP_SUB: begin
        if (s0 == sum_b_s) begin
          n_m_d = p0_q + sum_b_mag;
          n_s_d = s0;
        end else if (p0_q >= sum_b_mag) begin
          n_m_d = p0_q - sum_b_mag;
          n_s_d = s0;
        end else begin
          n_m_d = sum_b_mag - p0_q;
          n_s_d = sum_b_s;
        end
      end
      OP_MUL: begin
        n_s_d = s2;
        n_m_d = p2_q;
      end
      OP_DIV: begin
        d_s_d = s1;
        d_m_d = p1_q;
      end
      OP_NEG: begin
        n_s_d = !an_s_q;
        n_m_d = DW'(an_m_q);
        d_s_d = ad_s_q;
        d_m_d = DW'(ad_m_q);
      end
      OP_MAKE: begin
        n_s_d = an_s_q;
        n_m_d = DW'(an_m_q);
        d_s_d = ad_s_q;
        d_m_d = DW'(ad_m_q);
      end
      default: ;
    endcase

    pn = (an_s_q ^ ad_s_q) && (p0_q != '0);
    qn = (bn_s_q ^ bd_s_q) && (p1_q != '0);
    if (pn != qn) lt = pn;
    else if (!pn) lt = p0_q < p1_q;
    else lt = p0_q > p1_q;
    eq = (p0_q == p1_q) && ((p0_q == '0) || (s0 == s1));
    case (kind_q)
      OP_LT:   cmp_d = lt;
      OP_EQ:   cmp_d = eq;
      OP_LE:   cmp_d = lt || eq;
      OP_GT:   cmp_d = !(lt || eq);
      OP_GE:   cmp_d = !lt;
      default: cmp_d = 1'b0;
    endcase
  end

  assign g = v_q << k_q;
  assign trial     = {rem_q, dvd_q[DW-1]};
  assign trial_sub = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= req_i.kind;
      an_s_q <= an_x[W-1];
      ad_s_q <= ad_x[W-1];
      bn_s_q <= bn_x[W-1];
      bd_s_q <= bd_x[W-1];
      an_m_q <= an_x[W-1] ? -an_x : an_x;
      ad_m_q <= ad_x[W-1] ? -ad_x : ad_x;
      bn_m_q <= bn_x[W-1] ? -bn_x : bn_x;
      bd_m_q <= bd_x[W-1] ? -bd_x : bd_x;
    end
    if (cmd_i.mul_en) begin
      case (cmd_i.mul_sel)
        2'd0:    p0_q <= prod;
        2'd1:    p1_q <= prod;
        2'd2:    p2_q <= prod;
        default: p3_q <= prod;
      endcase
    end
    if (cmd_i.comb) begin
      n_s_q <= n_s_d;
      n_m_q <= n_m_d;
      d_s_q <= d_s_d;
      d_m_q <= d_m_d;
      cmp_q <= cmp_d;
      u_q   <= n_m_d;
      v_q   <= d_m_d;
      k_q   <= '0;
    end else if (cmd_i.gcd_step) begin
      if (!u_q[0] && !v_q[0]) begin
        u_q <= u_q >> 1;
        v_q <= v_q >> 1;
        k_q <= k_q + 1'b1;
      end else if (!u_q[0]) begin
        u_q <= u_q >> 1;
      end else if (!v_q[0]) begin
        v_q <= v_q >> 1;
      end else if (u_q >= v_q) begin
        u_q <= (u_q - v_q) >> 1;
      end else begin
        v_q <= (v_q - u_q) >> 1;
      end
    end
    if (cmd_i.div_start) begin
      dvd_q  <= cmd_i.div_sel ? d_m_q : n_m_q;
      dvs_q  <= g;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= dvd_q << 1;
      if (!trial_sub[DW]) begin
        rem_q  <= trial_sub[DW-1:0];
        quot_q <= {quot_q[DW-2:0], 1'b1};
      end else begin
        rem_q  <= trial[DW-1:0];
        quot_q <= {quot_q[DW-2:0], 1'b0};
      end
    end
    if (cmd_i.save_n) nm_q <= quot_q;
    if (cmd_i.finish) res_q <= res_d;
  end

  assign sts_o.special  = (kind_q > OP_MAKE) || (n_m_q == '0) || (d_m_q == '0);
  assign sts_o.gcd_done = (u_q == '0);

  assign rneg = n_s_q ^ d_s_q;
  assign ovf  = (quot_q >= Lim) || (rneg ? (nm_q > Lim) : (nm_q >= Lim));
  assign nm32 = 32'(nm_q);

  always_comb begin
    res_d = '0;
    case (kind_q) inside
      OP_LT, OP_EQ, OP_LE, OP_GT, OP_GE: res_d.cmp_true = cmp_q;
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_NEG, OP_MAKE: begin
        if (d_m_q == '0) begin
          res_d.res_num  = (n_m_q != '0) ? 32'sd1 : 32'sd0;
          res_d.zero_den = 1'b1;
        end else if (n_m_q == '0) begin
          res_d.res_den = 31'd1;
        end else if (ovf) begin
          res_d.overflow = 1'b1;
        end else begin
          res_d.res_num = rneg ? -nm32 : nm32;
          res_d.res_den = 31'(quot_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else valid_q <= cmd_i.finish;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;
endmodule
